[hw/rtl/fifo_with_prefix_reverse_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the prefix-reverse FIFO.
// These are used by the checker file of the block.
// ----------------------------------------------------------------------------
`ifndef FIFO_WITH_PREFIX_REVERSE_TOP_ASSERT_SVH
`define FIFO_WITH_PREFIX_REVERSE_TOP_ASSERT_SVH

// A property that is checked on every rising edge outside reset.
`define FWPR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A property that is also checked while reset is applied.
`define FWPR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/fwpr_pkg.sv]
// ----------------------------------------------------------------------------
// fwpr_pkg
// Request codes, status codes and sequencer states of the prefix-reverse FIFO.
// ----------------------------------------------------------------------------
package fwpr_pkg;

  // Request codes carried on req_type.
  typedef enum logic [1:0] {
    REQ_PUSH    = 2'd0,
    REQ_POP     = 2'd1,
    REQ_REVERSE = 2'd2
  } req_t;

  // Status codes returned with every result.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_BAD_K = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_WAIT,
    S_REV_RD,
    S_REV_WA,
    S_REV_WB,
    S_DONE
  } state_t;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned KLEN_W = 8;
  localparam int unsigned OCC_W  = 8;

endpackage

[hw/rtl/fifo_with_prefix_reverse_top.sv]
// ----------------------------------------------------------------------------
// fifo_with_prefix_reverse_top
// FIFO of signed 32-bit words that can also reverse its oldest k entries.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on the in channel (req_type, push_value, prefix_len) with
// valid/ready; each yields one result on the out channel (pop_value, status,
// occupancy) with valid/ready. The words sit in a circular buffer held in a
// synchronous memory with two read ports and one write port.
// From the input transfer, enqueue and rejected requests go straight to the
// done state, a dequeue first does one memory read, and a reverse of k
// entries runs floor(k/2) swaps, each a read of both ends followed by two
// writes through the single write port.
// One request is worked on at a time; in_ready is high only while the
// sequencer is idle. The result sits in an output register, so the next
// request is taken while the previous result waits for the receiver. If
// the receiver stalls, the sequencer holds its finished result until the
// output register frees up.
// Reset clears the head index, the count and all handshake state; the memory
// contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module fifo_with_prefix_reverse_top #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          req_type,
  input  logic signed [fwpr_pkg::WORD_W-1:0]  push_value,
  input  logic [fwpr_pkg::KLEN_W-1:0]         prefix_len,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [fwpr_pkg::WORD_W-1:0]  pop_value,
  output logic [1:0]                          status,
  output logic [fwpr_pkg::OCC_W-1:0]          occupancy
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned KW = (CW > fwpr_pkg::KLEN_W) ? CW : fwpr_pkg::KLEN_W;

  fwpr_pkg::state_t state, state_next;

  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [AW-1:0] lo;
  logic [AW-1:0] hi;

  logic [fwpr_pkg::WORD_W-1:0] res_pop;
  fwpr_pkg::status_t           res_status;

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [fwpr_pkg::WORD_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr_a;
  logic [AW-1:0]               mem_raddr_b;
  logic [fwpr_pkg::WORD_W-1:0] mem_rdata_a;
  logic [fwpr_pkg::WORD_W-1:0] mem_rdata_b;

  logic          in_xfer;
  logic          out_free;
  logic          is_full;
  logic          is_empty;
  logic          rev_bad;
  logic [KW-1:0] k_ext;
  logic [KW-1:0] k_last;

  // Circular slot of an offset from the head: one add and a wrap correction.
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign in_ready = (state == fwpr_pkg::S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);
  assign k_ext    = KW'(prefix_len);
  assign k_last   = k_ext - KW'(1);
  assign rev_bad  = is_empty || (k_ext == '0) || (k_ext > KW'(count));

  fwpr_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fwpr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory port control.
  always_comb begin
    state_next  = state;
    mem_we      = 1'b0;
    mem_waddr   = slot_of(head, lo);
    mem_wdata   = mem_rdata_b;
    mem_re      = 1'b0;
    mem_raddr_a = slot_of(head, lo);
    mem_raddr_b = slot_of(head, hi);
    case (state)
      fwpr_pkg::S_IDLE: begin
        if (in_valid) begin
          case (req_type)
            fwpr_pkg::REQ_PUSH: begin
              mem_we     = !is_full;
              mem_waddr  = slot_of(head, count[AW-1:0]);
              mem_wdata  = push_value;
              state_next = fwpr_pkg::S_DONE;
            end
            fwpr_pkg::REQ_POP: begin
              mem_re      = !is_empty;
              mem_raddr_a = head;
              state_next  = is_empty ? fwpr_pkg::S_DONE : fwpr_pkg::S_POP_WAIT;
            end
            fwpr_pkg::REQ_REVERSE: begin
              state_next = rev_bad ? fwpr_pkg::S_DONE : fwpr_pkg::S_REV_RD;
            end
            default: begin
              state_next = fwpr_pkg::S_DONE;
            end
          endcase
        end
      end
      fwpr_pkg::S_POP_WAIT: begin
        state_next = fwpr_pkg::S_DONE;
      end
      fwpr_pkg::S_REV_RD: begin
        // Fetch both ends of the remaining span, or finish once they meet.
        if (lo < hi) begin
          mem_re     = 1'b1;
          state_next = fwpr_pkg::S_REV_WA;
        end else begin
          state_next = fwpr_pkg::S_DONE;
        end
      end
      fwpr_pkg::S_REV_WA: begin
        mem_we     = 1'b1;
        mem_waddr  = slot_of(head, lo);
        mem_wdata  = mem_rdata_b;
        state_next = fwpr_pkg::S_REV_WB;
      end
      fwpr_pkg::S_REV_WB: begin
        mem_we     = 1'b1;
        mem_waddr  = slot_of(head, hi);
        mem_wdata  = mem_rdata_a;
        state_next = fwpr_pkg::S_REV_RD;
      end
      fwpr_pkg::S_DONE: begin
        if (out_free) begin
          state_next = fwpr_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fwpr_pkg::S_IDLE;
      end
    endcase
  end

  // Queue pointers: the head index and the count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      count <= '0;
    end else begin
      if (in_xfer) begin
        case (req_type)
          fwpr_pkg::REQ_PUSH: begin
            if (!is_full) begin
              count <= count + CW'(1);
            end
          end
          fwpr_pkg::REQ_POP: begin
            if (!is_empty) begin
              head  <= slot_of(head, AW'(1));
              count <= count - CW'(1);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Payload of the pending result and the swap offsets.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_pop <= '0;
      lo      <= '0;
      hi      <= k_last[AW-1:0];
      case (req_type)
        fwpr_pkg::REQ_PUSH: begin
          if (is_full) begin
            res_status <= fwpr_pkg::ST_FULL;
          end else begin
            res_status <= fwpr_pkg::ST_OK;
          end
        end
        fwpr_pkg::REQ_POP: begin
          if (is_empty) begin
            res_status <= fwpr_pkg::ST_EMPTY;
          end else begin
            res_status <= fwpr_pkg::ST_OK;
          end
        end
        fwpr_pkg::REQ_REVERSE: begin
          if (rev_bad) begin
            res_status <= fwpr_pkg::ST_BAD_K;
          end else begin
            res_status <= fwpr_pkg::ST_OK;
          end
        end
        default: begin
          res_status <= fwpr_pkg::ST_OK;
        end
      endcase
    end
    if (state == fwpr_pkg::S_POP_WAIT) begin
      res_pop <= mem_rdata_a;
    end
    if (state == fwpr_pkg::S_REV_WB) begin
      lo <= lo + AW'(1);
      hi <= hi - AW'(1);
    end
  end

  // Output register: loaded when the result is done and the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == fwpr_pkg::S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == fwpr_pkg::S_DONE && out_free) begin
      pop_value <= res_pop;
      status    <= res_status;
      occupancy <= fwpr_pkg::OCC_W'(count);
    end
  end

endmodule

[hw/rtl/fwpr_mem.sv]
// ----------------------------------------------------------------------------
// fwpr_mem
// Entry storage: one write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module fwpr_mem #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [fwpr_pkg::WORD_W-1:0]   wdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr_a,
  input  logic [AW-1:0]                 raddr_b,
  output logic [fwpr_pkg::WORD_W-1:0]   rdata_a,
  output logic [fwpr_pkg::WORD_W-1:0]   rdata_b
);

  logic [fwpr_pkg::WORD_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two read ports with registered data that holds between reads.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

[hw/rtl/fwpr_checker.sv]
// ----------------------------------------------------------------------------
// fwpr_checker
// Port-level checks of the prefix-reverse FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`include "fifo_with_prefix_reverse_top_assert.svh"

module fwpr_checker #(
  parameter int unsigned DEPTH = 128
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [fwpr_pkg::WORD_W-1:0]  pop_value,
  input logic [1:0]                          status,
  input logic [fwpr_pkg::OCC_W-1:0]          occupancy
);

  // A stalled result keeps its payload.
  `FWPR_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(pop_value) && $stable(status) && $stable(occupancy), "stalled result changed")

  // A dequeue on an empty FIFO reports no data and no entries.
  `FWPR_ASSERT(a_empty_zero, clk, rst, out_valid && status == fwpr_pkg::ST_EMPTY |-> pop_value == 0 && occupancy == 0, "empty dequeue result not zero")

  // An enqueue is refused only when every entry is taken.
  `FWPR_ASSERT(a_full_occ, clk, rst, out_valid && status == fwpr_pkg::ST_FULL |-> occupancy == fwpr_pkg::OCC_W'(DEPTH), "full status with spare room")

  // The sequencer is busy in the cycle after a request transfer.
  `FWPR_ASSERT(a_one_at_a_time, clk, rst, in_valid && in_ready |=> !in_ready, "request taken while busy")

  // Reset leaves no result on offer.
  `FWPR_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !out_valid, "result offered after reset")

endmodule

bind fifo_with_prefix_reverse_top fwpr_checker #(
  .DEPTH (DEPTH)
) u_fwpr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .pop_value (pop_value),
  .status    (status),
  .occupancy (occupancy)
);

[tb/tb_fifo_with_prefix_reverse_top.sv]
// ----------------------------------------------------------------------------
// tb_fifo_with_prefix_reverse_top
// Self-checking bench for the FIFO with prefix reverse. A short table of
// requests covers the empty and bad-k cases and the extreme words. A
// long random run of fill, drain and mixed episodes follows. Every result is
// compared with its typed-in value or a shadow copy of the circular buffer.
// Both handshakes idle at random, and the receiver holds off once for long
// enough to back the block up.
// ----------------------------------------------------------------------------
module tb_fifo_with_prefix_reverse_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH         = 128;
  localparam logic [1:0]  REQ_RESERVED  = 2'd3;
  localparam int unsigned RANDOM_ITEMS  = 1100;
  localparam int unsigned IDLE_PERCENT  = 27;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;

  // One result as the block reports it.
  typedef struct packed {
    logic signed [fwpr_pkg::WORD_W-1:0] pop_value;
    fwpr_pkg::status_t                  status;
    logic [fwpr_pkg::OCC_W-1:0]         occupancy;
  } fifo_result_t;

  // One row of the directed table. Rows with known_result set carry their
  // result typed in; the others are left to the shadow buffer.
  typedef struct packed {
    logic [1:0]                    req;
    logic [fwpr_pkg::WORD_W-1:0]   word;
    logic [fwpr_pkg::KLEN_W-1:0]   k;
    bit                            known_result;
    fifo_result_t                  result;
  } request_row_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic [1:0]                           req_type = 2'd0;
  logic signed [fwpr_pkg::WORD_W-1:0]   push_value = '0;
  logic [fwpr_pkg::KLEN_W-1:0]          prefix_len = '0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic signed [fwpr_pkg::WORD_W-1:0]   pop_value;
  logic [1:0]                           status;
  logic [fwpr_pkg::OCC_W-1:0]           occupancy;

  // Shadow copy of the buffer, kept in step with accepted requests.
  logic [fwpr_pkg::WORD_W-1:0] shadow_words [DEPTH];
  int unsigned                 shadow_head  = 0;
  int unsigned                 shadow_count = 0;

  fifo_result_t awaited_results [$];
  int unsigned  error_count   = 0;
  int unsigned  cycle_count   = 0;
  int unsigned  random_issued = 0;
  bit           steady        = 1'b0;
  bit           hold_request  = 1'b0;
  bit           hold_done     = 1'b0;

  fifo_with_prefix_reverse_top #(.DEPTH(DEPTH)) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .push_value (push_value),
    .prefix_len (prefix_len),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pop_value  (pop_value),
    .status     (status),
    .occupancy  (occupancy)
  );

  always #6 clk = ~clk;

  // Applies one request to the shadow buffer and returns its result.
  function automatic fifo_result_t apply_to_shadow(logic [1:0] req,
                                                   logic [fwpr_pkg::WORD_W-1:0] word,
                                                   logic [fwpr_pkg::KLEN_W-1:0] k);
    fifo_result_t                r;
    int unsigned                 lo;
    int unsigned                 hi;
    logic [fwpr_pkg::WORD_W-1:0] swap_word;
    r.pop_value = '0;
    r.status    = fwpr_pkg::ST_OK;
    case (req)
      fwpr_pkg::REQ_PUSH: begin
        if (shadow_count >= DEPTH) begin
          r.status = fwpr_pkg::ST_FULL;
        end else begin
          shadow_words[(shadow_head + shadow_count) % DEPTH] = word;
          shadow_count++;
        end
      end
      fwpr_pkg::REQ_POP: begin
        if (shadow_count == 0) begin
          r.status = fwpr_pkg::ST_EMPTY;
        end else begin
          r.pop_value  = shadow_words[shadow_head];
          shadow_head  = (shadow_head + 1) % DEPTH;
          shadow_count--;
        end
      end
      fwpr_pkg::REQ_REVERSE: begin
        if (shadow_count == 0 || k == 0 || k > shadow_count) begin
          r.status = fwpr_pkg::ST_BAD_K;
        end else begin
          lo = 0;
          hi = k - 1;
          while (lo < hi) begin
            swap_word = shadow_words[(shadow_head + lo) % DEPTH];
            shadow_words[(shadow_head + lo) % DEPTH] = shadow_words[(shadow_head + hi) % DEPTH];
            shadow_words[(shadow_head + hi) % DEPTH] = swap_word;
            lo++;
            hi--;
          end
        end
      end
      default: begin
      end
    endcase
    r.occupancy = fwpr_pkg::OCC_W'(shadow_count);
    return r;
  endfunction

  // Offers one request, waits for its transfer and records the awaited result.
  task automatic offer_request(input logic [1:0] req,
                               input logic [fwpr_pkg::WORD_W-1:0] word,
                               input logic [fwpr_pkg::KLEN_W-1:0] k, input bit known_result,
                               input fifo_result_t typed_result);
    fifo_result_t shadow_result;
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    in_valid   = 1'b1;
    req_type   = req;
    push_value = word;
    prefix_len = k;
    do @(posedge clk); while (!in_ready);
    shadow_result = apply_to_shadow(req, word, k);
    awaited_results.push_back(known_result ? typed_result : shadow_result);
    if (req != REQ_RESERVED) random_issued++;
    @(negedge clk);
  endtask

  // A random word with the extremes turning up now and then.
  function automatic logic [fwpr_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // A prefix length biased towards the edges of the current occupancy.
  function automatic logic [fwpr_pkg::KLEN_W-1:0] pick_prefix();
    case ($urandom_range(9))
      0:       return '0;
      1:       return (shadow_count < DEPTH) ? fwpr_pkg::KLEN_W'(shadow_count + 1)
                                             : fwpr_pkg::KLEN_W'(DEPTH);
      2:       return fwpr_pkg::KLEN_W'(shadow_count);
      3:       return fwpr_pkg::KLEN_W'(1);
      4:       return fwpr_pkg::KLEN_W'($urandom_range(DEPTH));
      default: return (shadow_count == 0)
                        ? fwpr_pkg::KLEN_W'($urandom_range(DEPTH))
                        : fwpr_pkg::KLEN_W'($urandom_range(shadow_count, 1));
    endcase
  endfunction

  // Plain random request whose result the shadow buffer predicts.
  task automatic offer_random(input logic [1:0] req);
    fifo_result_t unused;
    unused = '0;
    offer_request(req, pick_word(), pick_prefix(), 1'b0, unused);
  endtask

  // Receiver: random back-pressure, one long hold-off, and a calm window.
  initial begin
    @(negedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_ready = steady || ($urandom_range(99) >= IDLE_PERCENT);
      @(negedge clk);
    end
  end

  // Each result transfer is compared with the oldest awaited result.
  always @(posedge clk) begin
    fifo_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("result transfer with nothing awaited: pop_value %0d status %0d occupancy %0d",
               pop_value, status, occupancy);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        if (pop_value !== want.pop_value) begin
          $error("pop_value: expected %0d, got %0d", want.pop_value, pop_value);
          error_count++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          error_count++;
        end
        if (occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
          error_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stimulus.
  initial begin
    request_row_t directed_rows [23];
    int unsigned  episode_len;
    int unsigned  pick;
    directed_rows = '{
      // Empty buffer straight after reset.
      '{fwpr_pkg::REQ_POP,     32'h0,         8'd0,   1'b1,
        '{32'sd0, fwpr_pkg::ST_EMPTY, 8'd0}},
      '{fwpr_pkg::REQ_REVERSE, 32'h0,         8'd0,   1'b1,
        '{32'sd0, fwpr_pkg::ST_BAD_K, 8'd0}},
      '{fwpr_pkg::REQ_REVERSE, 32'h0,         8'd1,   1'b1,
        '{32'sd0, fwpr_pkg::ST_BAD_K, 8'd0}},
      '{REQ_RESERVED,          32'hFFFF_FFFF, 8'd128, 1'b1,
        '{32'sd0, fwpr_pkg::ST_OK,    8'd0}},
      // Extreme words.
      '{fwpr_pkg::REQ_PUSH,    32'h8000_0000, 8'd0,   1'b1,
        '{32'sd0, fwpr_pkg::ST_OK,    8'd1}},
      '{fwpr_pkg::REQ_PUSH,    32'h7FFF_FFFF, 8'd0,   1'b1,
        '{32'sd0, fwpr_pkg::ST_OK,    8'd2}},
      '{fwpr_pkg::REQ_PUSH,    32'hFFFF_FFFF, 8'd0,   1'b1,
        '{32'sd0, fwpr_pkg::ST_OK,    8'd3}},
      '{fwpr_pkg::REQ_PUSH,    32'h0000_0000, 8'd0,   1'b1,
        '{32'sd0, fwpr_pkg::ST_OK,    8'd4}},
      '{fwpr_pkg::REQ_PUSH,    32'h5A5A_A5A5, 8'd128, 1'b1,
        '{32'sd0, fwpr_pkg::ST_OK,    8'd5}},
      // Bad and trivial prefix lengths.
      '{fwpr_pkg::REQ_REVERSE, 32'h0,         8'd0,   1'b1,
        '{32'sd0, fwpr_pkg::ST_BAD_K, 8'd5}},
      '{fwpr_pkg::REQ_REVERSE, 32'h0,         8'd6,   1'b1,
        '{32'sd0, fwpr_pkg::ST_BAD_K, 8'd5}},
      '{fwpr_pkg::REQ_REVERSE, 32'h0,         8'd128, 1'b1,
        '{32'sd0, fwpr_pkg::ST_BAD_K, 8'd5}},
      '{fwpr_pkg::REQ_REVERSE, 32'h0,         8'd1,   1'b1,
        '{32'sd0, fwpr_pkg::ST_OK,    8'd5}},
      // Real reversals, checked through the dequeued order.
      '{fwpr_pkg::REQ_REVERSE, 32'h0,         8'd5,   1'b0, '0},
      '{fwpr_pkg::REQ_POP,     32'h0,         8'd0,   1'b0, '0},
      '{fwpr_pkg::REQ_REVERSE, 32'h0,         8'd2,   1'b0, '0},
      '{fwpr_pkg::REQ_POP,     32'h0,         8'd0,   1'b0, '0},
      '{REQ_RESERVED,          32'h1234_5678, 8'd3,   1'b0, '0},
      '{fwpr_pkg::REQ_REVERSE, 32'h0,         8'd3,   1'b0, '0},
      '{fwpr_pkg::REQ_POP,     32'h0,         8'd0,   1'b0, '0},
      '{fwpr_pkg::REQ_POP,     32'h0,         8'd0,   1'b0, '0},
      '{fwpr_pkg::REQ_POP,     32'h0,         8'd0,   1'b0, '0},
      '{fwpr_pkg::REQ_POP,     32'h0,         8'd0,   1'b0, '0}
    };

    // Reset.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table.
    foreach (directed_rows[i]) begin
      offer_request(directed_rows[i].req, directed_rows[i].word, directed_rows[i].k,
                    directed_rows[i].known_result, directed_rows[i].result);
    end

    // Random episodes: fill to full, drain to empty, or a mixed run.
    random_issued = 0;
    while (random_issued < RANDOM_ITEMS) begin
      if (random_issued >= 250) hold_request = 1'b1;
      steady = (random_issued >= 600 && random_issued < 800);
      pick = $urandom_range(99);
      if (pick < 12) begin
        while (shadow_count < DEPTH) offer_random(fwpr_pkg::REQ_PUSH);
        repeat ($urandom_range(3, 1)) offer_random(fwpr_pkg::REQ_PUSH);
        offer_request(fwpr_pkg::REQ_REVERSE, pick_word(), fwpr_pkg::KLEN_W'(DEPTH), 1'b0, '0);
        offer_random(fwpr_pkg::REQ_REVERSE);
      end else if (pick < 24) begin
        while (shadow_count > 0) offer_random(fwpr_pkg::REQ_POP);
        repeat ($urandom_range(2, 1)) offer_random(fwpr_pkg::REQ_POP);
        offer_random(fwpr_pkg::REQ_REVERSE);
      end else begin
        episode_len = $urandom_range(40, 10);
        repeat (episode_len) begin
          pick = $urandom_range(99);
          if (pick < 40)      offer_random(fwpr_pkg::REQ_PUSH);
          else if (pick < 70) offer_random(fwpr_pkg::REQ_POP);
          else if (pick < 97) offer_random(fwpr_pkg::REQ_REVERSE);
          else                offer_random(REQ_RESERVED);
        end
      end
    end
    steady   = 1'b0;
    in_valid = 1'b0;

    // Let every awaited result arrive, then allow for a late stray one.
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/fwpr_pkg.sv
hw/rtl/fwpr_mem.sv
hw/rtl/fifo_with_prefix_reverse_top.sv
hw/rtl/fwpr_checker.sv
tb/tb_fifo_with_prefix_reverse_top.sv
